/* design/bfe_pkg.sv */
// ----------------------------------------------------------------------------
// bfe_pkg
// Shared types, constants and helpers of the Bloom filter engine.
// ----------------------------------------------------------------------------
package bfe_pkg;

	localparam int unsigned MAX_BITS   = 65536;
	localparam int unsigned MAX_HASHES = 4;
	localparam int unsigned ROW_BITS   = 32;
	localparam int unsigned ROWS       = MAX_BITS / ROW_BITS;
	localparam int unsigned ROW_AW     = $clog2(ROWS);
	localparam int unsigned BIT_AW     = $clog2(ROW_BITS);
	localparam int unsigned IDX_W      = $clog2(MAX_BITS);
	localparam int unsigned NBITS_W    = 17;
	localparam int unsigned NHASH_W    = 3;
	localparam int unsigned HIX_W      = $clog2(MAX_HASHES);

	localparam logic [31:0] MM_C1   = 32'hcc9e2d51;
	localparam logic [31:0] MM_C2   = 32'h1b873593;
	localparam logic [31:0] MM_ADD  = 32'he6546b64;
	localparam logic [31:0] MIX_C1  = 32'h85ebca6b;
	localparam logic [31:0] MIX_C2  = 32'hc2b2ae35;

	localparam logic [NBITS_W-1:0] BITS_MIN   = NBITS_W'(8);
	localparam logic [NBITS_W-1:0] BITS_MAX   = NBITS_W'(MAX_BITS);
	localparam logic [NHASH_W-1:0] HASHES_MAX = NHASH_W'(MAX_HASHES);

	localparam logic [31:0] SEED0_RST = 32'hAAAAAAAA;
	localparam logic [31:0] SEED1_RST = 32'h55555555;
	localparam logic [31:0] SEED2_RST = 32'h33333333;
	localparam logic [31:0] SEED3_RST = 32'hCCCCCCCC;

	typedef enum logic [1:0] {
		MODE_INSERT = 2'd0,
		MODE_LOOKUP = 2'd1,
		MODE_DELETE = 2'd2,
		MODE_NONE   = 2'd3
	} mode_t;

	typedef enum logic [2:0] {
		REG_BIT_COUNT  = 3'd0,
		REG_HASH_COUNT = 3'd1,
		REG_SEED_ZERO  = 3'd2,
		REG_SEED_ONE   = 3'd3,
		REG_SEED_TWO   = 3'd4,
		REG_SEED_THREE = 3'd5
	} reg_idx_t;

	typedef enum logic [2:0] {
		F_IDLE, F_MUL1, F_MUL2, F_LANES, F_PUSH
	} front_state_t;

	typedef enum logic [3:0] {
		B_CLEAR, B_IDLE, B_TAIL1, B_TAIL2, B_MIX0, B_MIX1, B_MIX2, B_DIV, B_RD, B_WR, B_DONE
	} back_state_t;

	typedef logic [MAX_HASHES-1:0][31:0] lanes_t;

	typedef struct packed {
		lanes_t              lanes;
		logic [23:0]         gather;
		logic [1:0]          pos;
		logic [31:0]         len;
		logic [1:0]          mode;
		logic [NBITS_W-1:0]  nbits;
		logic [NHASH_W-1:0]  nhash;
	} job_t;

	typedef struct packed {
		logic        present;
		logic [31:0] item_count;
	} result_t;

	// Handshake of a request moving into a short queue.
	typedef struct packed {
		logic push;
		logic full;
	} qlink_t;

	function automatic logic [31:0] mul32(input logic [31:0] a, input logic [31:0] b);
		logic [63:0] p;
		p = a * b;
		return p[31:0];
	endfunction

	function automatic logic [31:0] rotl15(input logic [31:0] x);
		return {x[16:0], x[31:17]};
	endfunction

	function automatic logic [31:0] rotl13(input logic [31:0] x);
		return {x[18:0], x[31:19]};
	endfunction

endpackage

/* design/bfe_front.sv */
// ----------------------------------------------------------------------------
// bfe_front
// Takes key bytes, gathers 4-byte blocks and advances the hash lanes.
// ----------------------------------------------------------------------------
module bfe_front (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         take,
	input  logic [1:0]                   mode,
	input  logic [7:0]                   key_byte,
	input  logic                         byte_valid,
	input  logic                         last,
	input  logic [bfe_pkg::NBITS_W-1:0]  bit_count,
	input  logic [bfe_pkg::NHASH_W-1:0]  hash_count,
	input  logic [3:0][31:0]             seeds,
	output logic                         busy,
	output bfe_pkg::job_t                job,
	output bfe_pkg::qlink_t              jq_link,
	input  logic                         jq_full
);
	import bfe_pkg::*;

	front_state_t state_q, state_nx;
	logic         open_q;
	lanes_t       lanes_q, base_lanes;
	logic [23:0]  gather_q, base_gather, gather_nx;
	logic [1:0]   pos_q, base_pos;
	logic [31:0]  len_q, base_len;
	logic [1:0]   mode_q;
	logic         last_q;
	logic [31:0]  blk_q, k_q, mul_a, mul_b, prod;
	logic [NBITS_W-1:0] nbits_q, nbits_c;
	logic [NHASH_W-1:0] nhash_q, nhash_c;
	logic         push_c;

	always_comb begin
		for (int i = 0; i < MAX_HASHES; i++) begin
			base_lanes[i] = open_q ? lanes_q[i] : seeds[i % 4];
		end
		base_gather = open_q ? gather_q : 24'd0;
		base_pos    = open_q ? pos_q : 2'd0;
		base_len    = open_q ? len_q : 32'd0;
		case (base_pos)
			2'd0: gather_nx = {base_gather[23:8], key_byte};
			2'd1: gather_nx = {base_gather[23:16], key_byte, base_gather[7:0]};
			2'd2: gather_nx = {key_byte, base_gather[15:0]};
			default: gather_nx = base_gather;
		endcase
		if (bit_count < BITS_MIN) begin
			nbits_c = BITS_MIN;
		end else if (bit_count > BITS_MAX) begin
			nbits_c = BITS_MAX;
		end else begin
			nbits_c = bit_count;
		end
		if (hash_count == '0) begin
			nhash_c = NHASH_W'(1);
		end else if (hash_count > HASHES_MAX) begin
			nhash_c = HASHES_MAX;
		end else begin
			nhash_c = hash_count;
		end
	end

	assign mul_a = (state_q == F_MUL1) ? blk_q : rotl15(k_q);
	assign mul_b = (state_q == F_MUL1) ? MM_C1 : MM_C2;
	assign prod  = mul32(mul_a, mul_b);

	always_comb begin
		state_nx = state_q;
		case (state_q)
			F_IDLE: begin
				if (take && byte_valid && base_pos == 2'd3) begin
					state_nx = F_MUL1;
				end else if (take && last) begin
					state_nx = F_PUSH;
				end
			end
			F_MUL1:  state_nx = F_MUL2;
			F_MUL2:  state_nx = F_LANES;
			F_LANES: state_nx = last_q ? F_PUSH : F_IDLE;
			F_PUSH:  state_nx = jq_full ? F_PUSH : F_IDLE;
			default: state_nx = F_IDLE;
		endcase
	end

	always_comb begin
		busy   = (state_q != F_IDLE);
		push_c = (state_q == F_PUSH) && !jq_full;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= F_IDLE;
			open_q  <= 1'b0;
		end else begin
			state_q <= state_nx;
			if (take) begin
				open_q <= 1'b1;
			end else if (push_c) begin
				open_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			lanes_q <= base_lanes;
			mode_q  <= mode;
			last_q  <= last;
			nbits_q <= nbits_c;
			nhash_q <= nhash_c;
			if (byte_valid) begin
				len_q <= base_len + 32'd1;
				if (base_pos == 2'd3) begin
					blk_q    <= {key_byte, base_gather};
					gather_q <= 24'd0;
					pos_q    <= 2'd0;
				end else begin
					gather_q <= gather_nx;
					pos_q    <= base_pos + 2'd1;
				end
			end else begin
				len_q    <= base_len;
				gather_q <= base_gather;
				pos_q    <= base_pos;
			end
		end
		if (state_q == F_MUL1 || state_q == F_MUL2) begin
			k_q <= prod;
		end
		if (state_q == F_LANES) begin
			for (int i = 0; i < MAX_HASHES; i++) begin
				lanes_q[i] <= (rotl13(lanes_q[i] ^ k_q) << 2) + rotl13(lanes_q[i] ^ k_q)
					+ MM_ADD;
			end
		end
	end

	assign job.lanes  = lanes_q;
	assign job.gather = gather_q;
	assign job.pos    = pos_q;
	assign job.len    = len_q;
	assign job.mode   = mode_q;
	assign job.nbits  = nbits_q;
	assign job.nhash  = nhash_q;
	assign jq_link.push = push_c;
	assign jq_link.full = jq_full;

endmodule

/* design/bfe_jobq.sv */
// ----------------------------------------------------------------------------
// bfe_jobq
// Two-entry queue of finished keys between the front and the back.
// ----------------------------------------------------------------------------
module bfe_jobq (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            push,
	input  bfe_pkg::job_t   wdata,
	output logic            full,
	input  logic            pop,
	output bfe_pkg::job_t   rdata,
	output logic            empty
);
	import bfe_pkg::*;

	job_t       slot_q [2];
	logic       wp_q, rp_q;
	logic [1:0] cnt_q;

	assign full  = (cnt_q == 2'd2);
	assign empty = (cnt_q == 2'd0);
	assign rdata = slot_q[rp_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= 1'b0;
			rp_q  <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (push && !full) begin
				wp_q <= ~wp_q;
			end
			if (pop && !empty) begin
				rp_q <= ~rp_q;
			end
			cnt_q <= cnt_q + 2'((push && !full) ? 1 : 0) - 2'((pop && !empty) ? 1 : 0);
		end
	end

	always_ff @(posedge clk) begin
		if (push && !full) begin
			slot_q[wp_q] <= wdata;
		end
	end

endmodule

/* design/bfe_back.sv */
// ----------------------------------------------------------------------------
// bfe_back
// Finishes each hash, reduces it to a bit index and, for insert and delete, updates the bit store.
// ----------------------------------------------------------------------------
module bfe_back (
	input  logic              clk,
	input  logic              arst_n,
	input  bfe_pkg::job_t     job,
	input  logic              job_empty,
	output logic              job_pop,
	output bfe_pkg::result_t  res,
	output bfe_pkg::qlink_t   rq_link,
	input  logic              res_full,
	output logic              clearing
);
	import bfe_pkg::*;

	back_state_t        state_q, state_nx;
	job_t               job_q;
	logic [HIX_W-1:0]   hix_q;
	logic [31:0]        t_q, h_q, dvd_q, lane, mul_a, mul_b, prod, h0, h1, h2;
	logic [NBITS_W-1:0] rem_q;
	logic [NBITS_W:0]   trial;
	logic [4:0]         cnt_q;
	logic [ROW_AW-1:0]  clr_q, mem_addr;
	logic [31:0]        mem [ROWS];
	logic [31:0]        rdata_q, mem_wdata, mask;
	logic               mem_we, all_set_q, push_c, hit;
	logic [31:0]        total_q, total_nx;

	assign lane = job_q.lanes[hix_q];
	assign h0   = lane ^ ((job_q.pos != 2'd0) ? t_q : 32'd0) ^ job_q.len;
	assign h1   = h_q ^ (h_q >> 13);
	assign h2   = h_q ^ (h_q >> 16);

	always_comb begin
		case (state_q)
			B_TAIL1: begin mul_a = {8'd0, job_q.gather}; mul_b = MM_C1; end
			B_TAIL2: begin mul_a = rotl15(t_q);          mul_b = MM_C2; end
			B_MIX0:  begin mul_a = h0 ^ (h0 >> 16);      mul_b = MIX_C1; end
			default: begin mul_a = h1;                   mul_b = MIX_C2; end
		endcase
		prod  = mul32(mul_a, mul_b);
		trial = {rem_q, dvd_q[31]} - {1'b0, job_q.nbits};
	end

	always_comb begin
		state_nx = state_q;
		case (state_q)
			B_CLEAR: state_nx = (clr_q == ROW_AW'(ROWS - 1)) ? B_IDLE : B_CLEAR;
			B_IDLE:  state_nx = job_empty ? B_IDLE : B_TAIL1;
			B_TAIL1: state_nx = B_TAIL2;
			B_TAIL2: state_nx = B_MIX0;
			B_MIX0:  state_nx = B_MIX1;
			B_MIX1:  state_nx = B_MIX2;
			B_MIX2:  state_nx = B_DIV;
			B_DIV:   state_nx = (cnt_q == 5'd31) ? B_RD : B_DIV;
			B_RD:    state_nx = B_WR;
			B_WR: begin
				state_nx = (hix_q == HIX_W'(job_q.nhash - NHASH_W'(1)))
					? B_DONE : B_TAIL1;
			end
			B_DONE:  state_nx = res_full ? B_DONE : B_IDLE;
			default: state_nx = B_IDLE;
		endcase
	end

	always_comb begin
		clearing  = (state_q == B_CLEAR);
		job_pop   = (state_q == B_IDLE) && !job_empty;
		push_c    = (state_q == B_DONE) && !res_full;
		mask      = 32'd1 << rem_q[BIT_AW-1:0];
		hit       = (rdata_q & mask) != 32'd0;
		mem_we    = 1'b0;
		mem_addr  = rem_q[IDX_W-1:BIT_AW];
		mem_wdata = rdata_q;
		if (state_q == B_CLEAR) begin
			mem_we    = 1'b1;
			mem_addr  = clr_q;
			mem_wdata = 32'd0;
		end else if (state_q == B_WR) begin
			if (job_q.mode == MODE_INSERT) begin
				mem_we    = 1'b1;
				mem_wdata = rdata_q | mask;
			end else if (job_q.mode == MODE_DELETE) begin
				mem_we    = 1'b1;
				mem_wdata = rdata_q & ~mask;
			end
		end
		total_nx = total_q;
		if (job_q.mode == MODE_INSERT && total_q != 32'hFFFFFFFF) begin
			total_nx = total_q + 32'd1;
		end else if (job_q.mode == MODE_DELETE && total_q != 32'd0) begin
			total_nx = total_q - 32'd1;
		end
	end

	assign res.present    = (job_q.mode == MODE_LOOKUP) && all_set_q;
	assign res.item_count = total_nx;
	assign rq_link.push   = push_c;
	assign rq_link.full   = res_full;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= B_CLEAR;
			clr_q   <= '0;
			total_q <= 32'd0;
		end else begin
			state_q <= state_nx;
			if (state_q == B_CLEAR) begin
				clr_q <= clr_q + ROW_AW'(1);
			end
			if (push_c) begin
				total_q <= total_nx;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[mem_addr] <= mem_wdata;
		end
		rdata_q <= mem[mem_addr];
	end

	always_ff @(posedge clk) begin
		case (state_q)
			B_IDLE: begin
				job_q     <= job;
				hix_q     <= '0;
				all_set_q <= 1'b1;
			end
			B_TAIL1, B_TAIL2: t_q <= prod;
			B_MIX0, B_MIX1:   h_q <= prod;
			B_MIX2: begin
				dvd_q <= h2;
				rem_q <= '0;
				cnt_q <= 5'd0;
			end
			B_DIV: begin
				// Restoring division, one quotient bit per cycle; only the remainder is kept.
				rem_q <= trial[NBITS_W] ? {rem_q[NBITS_W-2:0], dvd_q[31]}
				                       : trial[NBITS_W-1:0];
				dvd_q <= dvd_q << 1;
				cnt_q <= cnt_q + 5'd1;
			end
			B_WR: begin
				hix_q <= hix_q + HIX_W'(1);
				if (job_q.mode == MODE_LOOKUP && !hit) begin
					all_set_q <= 1'b0;
				end
			end
			default: begin
			end
		endcase
	end

	a_rem_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == B_RD) |-> ({15'd0, rem_q} < {15'd0, job_q.nbits}))
		else $error("bit index not below bit count");

	a_hash_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == B_WR) |-> ({1'b0, hix_q} < job_q.nhash))
		else $error("hash number beyond hash count");

	a_clear_ends: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == B_CLEAR && clr_q == ROW_AW'(ROWS - 1)) |=> (state_q == B_IDLE))
		else $error("clearing pass did not end");

	a_no_pop_in_clear: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == B_CLEAR) |-> !job_pop)
		else $error("job taken during clearing pass");

endmodule

/* design/bfe_resq.sv */
// ----------------------------------------------------------------------------
// bfe_resq
// Two-entry result queue that presents the oldest result to the output side.
// ----------------------------------------------------------------------------
module bfe_resq (
	input  logic              clk,
	input  logic              arst_n,
	input  bfe_pkg::qlink_t   link,
	input  bfe_pkg::result_t  wdata,
	output logic              full,
	input  logic              pop,
	output bfe_pkg::result_t  rdata,
	output logic              empty
);
	import bfe_pkg::*;

	result_t    slot_q [2];
	logic       wp_q, rp_q;
	logic [1:0] cnt_q;
	logic       wr, rd;

	assign full  = (cnt_q == 2'd2);
	assign empty = (cnt_q == 2'd0);
	assign rdata = slot_q[rp_q];
	assign wr    = link.push && !full;
	assign rd    = pop && !empty;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= 1'b0;
			rp_q  <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (wr) begin
				wp_q <= ~wp_q;
			end
			if (rd) begin
				rp_q <= ~rp_q;
			end
			cnt_q <= cnt_q + 2'(wr ? 1 : 0) - 2'(rd ? 1 : 0);
		end
	end

	always_ff @(posedge clk) begin
		if (wr) begin
			slot_q[wp_q] <= wdata;
		end
	end

endmodule

/* design/bloom_filter_engine_core.sv */
// ----------------------------------------------------------------------------
// bloom_filter_engine_core
// Bloom filter over MurmurHash3 x86_32 keys with insert, lookup and delete.
//
//   Channel   Handshake        Payload
//   input     push / full      mode, key_byte, byte_valid, last
//   result    empty / pop      present, item_count
//   config    cfg_we           cfg_idx, cfg_wdata
//
// A key byte is taken while the front is idle; full stays high while a byte that
// completes a 4-byte block passes through MUL1, MUL2 (the single shared multiplier
// of the front) and LANES, and while the item that ends a key waits in PUSH to
// queue the key for the back. For each hash the back runs the tail and final mix
// multiplies, a 32-step remainder and one bit-store read-modify-write (a lookup
// only reads), plus IDLE and DONE per key. After reset the back clears all 2048
// rows of the bit store, one 32-bit row per cycle, with full held high. Either
// side may stall without losing requests; two keys and two results can wait in the queues.
// ----------------------------------------------------------------------------
module bloom_filter_engine_core (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        push,
	output logic        full,
	input  logic [1:0]  mode,
	input  logic [7:0]  key_byte,
	input  logic        byte_valid,
	input  logic        last,
	output logic        empty,
	input  logic        pop,
	output logic        present,
	output logic [31:0] item_count,
	input  logic        cfg_we,
	input  logic [2:0]  cfg_idx,
	input  logic [31:0] cfg_wdata
);
	import bfe_pkg::*;

	logic [NBITS_W-1:0] bit_count_q;
	logic [NHASH_W-1:0] hash_count_q;
	logic [3:0][31:0]   seeds_q;
	logic               front_busy, clearing, take;
	logic               jq_full, jq_empty, jq_pop, rq_full;
	job_t               job_in, job_out;
	qlink_t             jq_link, rq_link;
	result_t            res_in, res_out;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bit_count_q  <= BITS_MAX;
			hash_count_q <= HASHES_MAX;
			seeds_q      <= {SEED3_RST, SEED2_RST, SEED1_RST, SEED0_RST};
		end else if (cfg_we) begin
			case (reg_idx_t'(cfg_idx))
				REG_BIT_COUNT:  bit_count_q  <= cfg_wdata[NBITS_W-1:0];
				REG_HASH_COUNT: hash_count_q <= cfg_wdata[NHASH_W-1:0];
				REG_SEED_ZERO:  seeds_q[0]   <= cfg_wdata;
				REG_SEED_ONE:   seeds_q[1]   <= cfg_wdata;
				REG_SEED_TWO:   seeds_q[2]   <= cfg_wdata;
				REG_SEED_THREE: seeds_q[3]   <= cfg_wdata;
				default: begin
				end
			endcase
		end
	end

	assign full = front_busy || clearing;
	assign take = push && !full;

	bfe_front u_front (
		.clk(clk), .arst_n(arst_n), .take(take), .mode(mode), .key_byte(key_byte),
		.byte_valid(byte_valid), .last(last), .bit_count(bit_count_q),
		.hash_count(hash_count_q), .seeds(seeds_q), .busy(front_busy), .job(job_in),
		.jq_link(jq_link), .jq_full(jq_full)
	);

	bfe_jobq u_jobq (
		.clk(clk), .arst_n(arst_n), .push(jq_link.push), .wdata(job_in), .full(jq_full),
		.pop(jq_pop), .rdata(job_out), .empty(jq_empty)
	);

	bfe_back u_back (
		.clk(clk), .arst_n(arst_n), .job(job_out), .job_empty(jq_empty), .job_pop(jq_pop),
		.res(res_in), .rq_link(rq_link), .res_full(rq_full), .clearing(clearing)
	);

	bfe_resq u_resq (
		.clk(clk), .arst_n(arst_n), .link(rq_link), .wdata(res_in), .full(rq_full),
		.pop(pop), .rdata(res_out), .empty(empty)
	);

	assign present    = res_out.present;
	assign item_count = res_out.item_count;

endmodule
